// ===== src/usvg_pkg.sv =====
// Shared types, constants and arctangent table for the UV sphere vertex generator.
package usvg_pkg;

    localparam int CNT_W        = 9;
    localparam int SEQ_W        = 16;
    localparam int OUT_W        = 16;
    localparam int ANG_W        = 34;
    localparam int PROD_W       = 64;
    localparam int DIV_STEPS    = 32;
    localparam int CORDIC_STEPS = 30;
    localparam int STEP_W       = 5;
    localparam int MIN_COUNT    = 3;
    localparam int RESET_COUNT  = 24;

    localparam logic signed [ANG_W-1:0] CORDIC_GAIN = 34'sd652032874;
    localparam logic signed [ANG_W-1:0] QUARTER     = 34'sd1073741824;
    localparam logic signed [ANG_W-1:0] HALF        = 34'sd2147483648;

    localparam logic REG_STACK_COUNT = 1'b0;
    localparam logic REG_SLICE_COUNT = 1'b1;

    typedef enum logic [1:0] {
        KIND_TOP,
        KIND_RING,
        KIND_BOTTOM
    } kind_t;

    typedef struct packed {
        kind_t              kind;
        logic [CNT_W-1:0]   ring;
        logic [CNT_W-1:0]   point;
        logic [CNT_W-1:0]   stacks;
        logic [CNT_W-1:0]   slices;
        logic [SEQ_W-1:0]   seq;
    } job_t;

    function automatic logic [29:0] atan_turn(input logic [STEP_W-1:0] k);
        logic [29:0] v;
        case (k)
            5'd0:    v = 30'd536870912;
            5'd1:    v = 30'd316933406;
            5'd2:    v = 30'd167458907;
            5'd3:    v = 30'd85004756;
            5'd4:    v = 30'd42667331;
            5'd5:    v = 30'd21354465;
            5'd6:    v = 30'd10679838;
            5'd7:    v = 30'd5340245;
            5'd8:    v = 30'd2670163;
            5'd9:    v = 30'd1335087;
            5'd10:   v = 30'd667544;
            5'd11:   v = 30'd333772;
            5'd12:   v = 30'd166886;
            5'd13:   v = 30'd83443;
            5'd14:   v = 30'd41722;
            5'd15:   v = 30'd20861;
            5'd16:   v = 30'd10430;
            5'd17:   v = 30'd5215;
            5'd18:   v = 30'd2608;
            5'd19:   v = 30'd1304;
            5'd20:   v = 30'd652;
            5'd21:   v = 30'd326;
            5'd22:   v = 30'd163;
            5'd23:   v = 30'd81;
            5'd24:   v = 30'd41;
            5'd25:   v = 30'd20;
            5'd26:   v = 30'd10;
            5'd27:   v = 30'd5;
            5'd28:   v = 30'd3;
            5'd29:   v = 30'd1;
            default: v = 30'd0;
        endcase
        return v;
    endfunction

endpackage

// ===== src/usvg_front.sv =====
// Front end: accepts ticks, walks poles, rings and points, issues one job per vertex.
module usvg_front #(
    parameter int MAX_STACKS = 256,
    parameter int MAX_SLICES = 256
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_stall,
    input  logic                          restart,
    input  logic [usvg_pkg::CNT_W-1:0]    stack_count,
    input  logic [usvg_pkg::CNT_W-1:0]    slice_count,
    input  logic                          full,
    output logic                          push,
    output usvg_pkg::job_t                job
);

    typedef enum logic [1:0] {
        PH_TOP,
        PH_RING,
        PH_BOTTOM
    } phase_t;

    phase_t                       phase_reg, phase_next;
    logic [usvg_pkg::CNT_W-1:0]   ring_reg, ring_next;
    logic [usvg_pkg::CNT_W-1:0]   point_reg, point_next;
    logic [usvg_pkg::SEQ_W-1:0]   seq_reg, seq_next;

    logic [usvg_pkg::CNT_W-1:0]   st, sl;
    logic                         accept;

    always_comb
    begin
        if (32'(stack_count) < usvg_pkg::MIN_COUNT)
            st = usvg_pkg::CNT_W'(usvg_pkg::MIN_COUNT);
        else if (32'(stack_count) > MAX_STACKS)
            st = usvg_pkg::CNT_W'(MAX_STACKS);
        else
            st = stack_count;
        if (32'(slice_count) < usvg_pkg::MIN_COUNT)
            sl = usvg_pkg::CNT_W'(usvg_pkg::MIN_COUNT);
        else if (32'(slice_count) > MAX_SLICES)
            sl = usvg_pkg::CNT_W'(MAX_SLICES);
        else
            sl = slice_count;
    end

    assign accept   = in_valid && !full;
    assign in_stall = full;
    assign push     = accept;

    always_comb
    begin
        phase_t                     ph;
        logic [usvg_pkg::CNT_W-1:0] r;
        logic [usvg_pkg::CNT_W-1:0] p;
        logic [usvg_pkg::SEQ_W-1:0] s;

        ph = phase_reg;
        r  = ring_reg;
        p  = point_reg;
        s  = seq_reg;
        if (restart || !(phase_reg inside {PH_RING, PH_BOTTOM}))
        begin
            ph = PH_TOP;
            s  = '0;
        end
        if (ph == PH_RING)
        begin
            if (p >= sl)
            begin
                p = '0;
                r = r + 1'b1;
            end
            if (r >= st - 1'b1)
                ph = PH_BOTTOM;
        end

        job.ring   = r;
        job.point  = p;
        job.stacks = st;
        job.slices = sl;
        job.seq    = s;

        phase_next = ph;
        ring_next  = r;
        point_next = p;
        case (ph)
            PH_TOP:
            begin
                job.kind   = usvg_pkg::KIND_TOP;
                ring_next  = usvg_pkg::CNT_W'(1);
                point_next = '0;
                phase_next = PH_RING;
            end
            PH_BOTTOM:
            begin
                job.kind   = usvg_pkg::KIND_BOTTOM;
                phase_next = PH_TOP;
            end
            default:
            begin
                job.kind   = usvg_pkg::KIND_RING;
                point_next = p + 1'b1;
                if (point_next >= sl)
                begin
                    point_next = '0;
                    ring_next  = r + 1'b1;
                    if (ring_next >= st - 1'b1)
                        phase_next = PH_BOTTOM;
                end
            end
        endcase
        seq_next = s + 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_TOP;
            ring_reg  <= '0;
            point_reg <= '0;
            seq_reg   <= '0;
        end
        else if (accept)
        begin
            phase_reg <= phase_next;
            ring_reg  <= ring_next;
            point_reg <= point_next;
            seq_reg   <= seq_next;
        end
    end

endmodule

// ===== src/usvg_queue.sv =====
// Two-entry job queue between the front end and the arithmetic back end.
module usvg_queue (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           push,
    input  usvg_pkg::job_t push_job,
    output logic           full,
    input  logic           pop,
    output logic           q_valid,
    output usvg_pkg::job_t q_job
);

    localparam int DEPTH = 2;
    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);

    usvg_pkg::job_t   entry_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [CNT_W-1:0] count_reg;

    assign full    = (count_reg == CNT_W'(DEPTH));
    assign q_valid = (count_reg != '0);
    assign q_job   = entry_reg[rd_ptr_reg];

    always_ff @(posedge clk)
    begin
        if (push && !full)
            entry_reg[wr_ptr_reg] <= push_job;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push && !full)
                wr_ptr_reg <= (32'(wr_ptr_reg) == DEPTH - 1) ? '0 : wr_ptr_reg + 1'b1;
            if (pop && q_valid)
                rd_ptr_reg <= (32'(rd_ptr_reg) == DEPTH - 1) ? '0 : rd_ptr_reg + 1'b1;
            count_reg <= count_reg + CNT_W'(push && !full) - CNT_W'(pop && q_valid);
        end
    end

    a_no_push_full: assert property (@(posedge clk) disable iff (!rst_n)
        full |-> !push)
        else $error("push into full queue");
    a_no_pop_empty: assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> q_valid)
        else $error("pop from empty queue");
    a_count_step: assert property (@(posedge clk) disable iff (!rst_n)
        (push && !pop) |=> count_reg == $past(count_reg) + 1'b1)
        else $error("queue count did not advance");

endmodule

// ===== src/usvg_back.sv =====
// Back end: divider for the angles, two shared CORDIC rotators, products and output register.
module usvg_back #(
    parameter int FRAC_BITS = 14
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               q_valid,
    input  usvg_pkg::job_t                     q_job,
    output logic                               pop,
    output logic                               out_valid,
    input  logic                               out_stall,
    output logic signed [usvg_pkg::OUT_W-1:0]  pos_x,
    output logic signed [usvg_pkg::OUT_W-1:0]  pos_y,
    output logic signed [usvg_pkg::OUT_W-1:0]  pos_z,
    output logic [usvg_pkg::SEQ_W-1:0]         vertex_number,
    output logic                               last
);

    localparam int AW = usvg_pkg::ANG_W;
    localparam int PW = usvg_pkg::PROD_W;
    localparam int SH_Y = 30 - FRAC_BITS;
    localparam int SH_P = 60 - FRAC_BITS;
    localparam logic signed [PW:0] RND_Y   = (65'sd1 <<< SH_Y) >>> 1;
    localparam logic signed [PW:0] RND_P   = (65'sd1 <<< SH_P) >>> 1;
    localparam logic signed [PW:0] LIM     = 65'sd1 <<< FRAC_BITS;
    localparam logic signed [PW:0] NEG_LIM = -LIM;

    typedef enum logic [2:0] {
        S_IDLE,
        S_DIV,
        S_FOLD,
        S_ROT,
        S_MULX,
        S_MULZ,
        S_ROUND,
        S_OUT
    } state_t;

    state_t                        state_reg;
    logic [usvg_pkg::STEP_W-1:0]   step_reg;
    logic [9:0]                    lat_rem_reg, lon_rem_reg;
    logic [9:0]                    lat_div_reg, lon_div_reg;
    logic [31:0]                   lat_low_reg, lon_low_reg;
    logic [31:0]                   lat_q_reg, lon_q_reg;
    logic signed [AW-1:0]          lat_x_reg, lat_y_reg, lat_a_reg;
    logic signed [AW-1:0]          lon_x_reg, lon_y_reg, lon_a_reg;
    logic                          lat_neg_reg, lon_neg_reg;
    logic signed [PW-1:0]          prod_reg;
    logic [usvg_pkg::OUT_W-1:0]    res_x_reg, res_y_reg, res_z_reg;
    logic [usvg_pkg::SEQ_W-1:0]    seq_reg;
    logic                          last_reg;
    logic                          out_valid_reg;
    logic [usvg_pkg::OUT_W-1:0]    pos_x_reg, pos_y_reg, pos_z_reg;
    logic [usvg_pkg::SEQ_W-1:0]    vnum_reg;
    logic                          olast_reg;

    function automatic logic [AW:0] fold(input logic [31:0] ph);
        logic signed [AW-1:0] a;
        logic                 neg;
        a   = {{(AW-32){ph[31]}}, ph};
        neg = 1'b0;
        if (a > usvg_pkg::QUARTER)
        begin
            a   = a - usvg_pkg::HALF;
            neg = 1'b1;
        end
        else if (a < -usvg_pkg::QUARTER)
        begin
            a   = a + usvg_pkg::HALF;
            neg = 1'b1;
        end
        return {neg, a};
    endfunction

    function automatic logic [usvg_pkg::OUT_W-1:0] round_clamp(
        input logic signed [PW-1:0] v,
        input logic signed [PW:0]   rnd,
        input int                   sh
    );
        logic signed [PW:0] s;
        s = $signed({v[PW-1], v}) + rnd;
        s = s >>> sh;
        if (s > LIM)
            s = LIM;
        else if (s < NEG_LIM)
            s = NEG_LIM;
        return s[usvg_pkg::OUT_W-1:0];
    endfunction

    logic [10:0]             lat_t, lon_t;
    logic                    lat_ge, lon_ge;
    logic [AW:0]             lat_f, lon_f;
    logic signed [AW-1:0]    atan_v;
    logic signed [AW-1:0]    lat_xs, lat_ys, lon_xs, lon_ys;
    logic signed [AW-1:0]    ca_w, sa_w, co_w, so_w;
    logic signed [31:0]      ca, co, so;
    logic                    out_free;

    assign lat_t  = {lat_rem_reg, lat_low_reg[31]};
    assign lon_t  = {lon_rem_reg, lon_low_reg[31]};
    assign lat_ge = lat_t >= {1'b0, lat_div_reg};
    assign lon_ge = lon_t >= {1'b0, lon_div_reg};
    assign lat_f  = fold(32'h4000_0000 - lat_q_reg);
    assign lon_f  = fold(32'd0 - lon_q_reg);
    assign atan_v = {{(AW-30){1'b0}}, usvg_pkg::atan_turn(step_reg)};
    assign lat_xs = lat_x_reg >>> step_reg;
    assign lat_ys = lat_y_reg >>> step_reg;
    assign lon_xs = lon_x_reg >>> step_reg;
    assign lon_ys = lon_y_reg >>> step_reg;
    assign ca_w   = lat_neg_reg ? -lat_x_reg : lat_x_reg;
    assign sa_w   = lat_neg_reg ? -lat_y_reg : lat_y_reg;
    assign co_w   = lon_neg_reg ? -lon_x_reg : lon_x_reg;
    assign so_w   = lon_neg_reg ? -lon_y_reg : lon_y_reg;
    assign ca     = ca_w[31:0];
    assign co     = co_w[31:0];
    assign so     = so_w[31:0];
    assign out_free = !out_valid_reg || !out_stall;
    assign pop    = (state_reg == S_IDLE) && q_valid;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            step_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= (out_valid_reg && out_stall) || (state_reg == S_OUT && out_free);
            case (state_reg)
                S_IDLE:
                begin
                    if (q_valid)
                    begin
                        seq_reg  <= q_job.seq;
                        last_reg <= (q_job.kind == usvg_pkg::KIND_BOTTOM);
                        res_x_reg <= '0;
                        res_z_reg <= '0;
                        res_y_reg <= (q_job.kind == usvg_pkg::KIND_BOTTOM) ?
                                     NEG_LIM[usvg_pkg::OUT_W-1:0] : LIM[usvg_pkg::OUT_W-1:0];
                        lat_rem_reg <= {1'b0, q_job.ring};
                        lon_rem_reg <= {q_job.point, 1'b0};
                        lat_div_reg <= {q_job.stacks, 1'b0};
                        lon_div_reg <= {q_job.slices, 1'b0};
                        lat_low_reg <= 32'(q_job.stacks);
                        lon_low_reg <= 32'(q_job.slices);
                        step_reg    <= '0;
                        state_reg   <= (q_job.kind == usvg_pkg::KIND_RING) ? S_DIV : S_OUT;
                    end
                end
                S_DIV:
                begin
                    lat_rem_reg <= lat_ge ? 10'(lat_t - {1'b0, lat_div_reg}) : lat_t[9:0];
                    lon_rem_reg <= lon_ge ? 10'(lon_t - {1'b0, lon_div_reg}) : lon_t[9:0];
                    lat_low_reg <= {lat_low_reg[30:0], 1'b0};
                    lon_low_reg <= {lon_low_reg[30:0], 1'b0};
                    lat_q_reg   <= {lat_q_reg[30:0], lat_ge};
                    lon_q_reg   <= {lon_q_reg[30:0], lon_ge};
                    step_reg    <= step_reg + 1'b1;
                    if (32'(step_reg) == usvg_pkg::DIV_STEPS - 1)
                        state_reg <= S_FOLD;
                end
                S_FOLD:
                begin
                    lat_neg_reg <= lat_f[AW];
                    lon_neg_reg <= lon_f[AW];
                    lat_a_reg   <= lat_f[AW-1:0];
                    lon_a_reg   <= lon_f[AW-1:0];
                    lat_x_reg   <= usvg_pkg::CORDIC_GAIN;
                    lon_x_reg   <= usvg_pkg::CORDIC_GAIN;
                    lat_y_reg   <= '0;
                    lon_y_reg   <= '0;
                    step_reg    <= '0;
                    state_reg   <= S_ROT;
                end
                S_ROT:
                begin
                    if (!lat_a_reg[AW-1])
                    begin
                        lat_x_reg <= lat_x_reg - lat_ys;
                        lat_y_reg <= lat_y_reg + lat_xs;
                        lat_a_reg <= lat_a_reg - atan_v;
                    end
                    else
                    begin
                        lat_x_reg <= lat_x_reg + lat_ys;
                        lat_y_reg <= lat_y_reg - lat_xs;
                        lat_a_reg <= lat_a_reg + atan_v;
                    end
                    if (!lon_a_reg[AW-1])
                    begin
                        lon_x_reg <= lon_x_reg - lon_ys;
                        lon_y_reg <= lon_y_reg + lon_xs;
                        lon_a_reg <= lon_a_reg - atan_v;
                    end
                    else
                    begin
                        lon_x_reg <= lon_x_reg + lon_ys;
                        lon_y_reg <= lon_y_reg - lon_xs;
                        lon_a_reg <= lon_a_reg + atan_v;
                    end
                    step_reg <= step_reg + 1'b1;
                    if (32'(step_reg) == usvg_pkg::CORDIC_STEPS - 1)
                        state_reg <= S_MULX;
                end
                S_MULX:
                begin
                    prod_reg  <= ca * co;
                    res_y_reg <= round_clamp({{(PW-AW){sa_w[AW-1]}}, sa_w}, RND_Y, SH_Y);
                    state_reg <= S_MULZ;
                end
                S_MULZ:
                begin
                    res_x_reg <= round_clamp(prod_reg, RND_P, SH_P);
                    prod_reg  <= ca * so;
                    state_reg <= S_ROUND;
                end
                S_ROUND:
                begin
                    res_z_reg <= round_clamp(prod_reg, RND_P, SH_P);
                    state_reg <= S_OUT;
                end
                S_OUT:
                begin
                    if (out_free)
                    begin
                        pos_x_reg     <= res_x_reg;
                        pos_y_reg     <= res_y_reg;
                        pos_z_reg     <= res_z_reg;
                        vnum_reg      <= seq_reg;
                        olast_reg     <= last_reg;
                        state_reg     <= S_IDLE;
                    end
                end
                default:
                    state_reg <= S_IDLE;
            endcase
        end
    end

    assign out_valid     = out_valid_reg;
    assign pos_x         = pos_x_reg;
    assign pos_y         = pos_y_reg;
    assign pos_z         = pos_z_reg;
    assign vertex_number = vnum_reg;
    assign last          = olast_reg;

    a_pole_axis: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && olast_reg) |-> (pos_x_reg == '0 && pos_z_reg == '0))
        else $error("bottom pole off axis");
    a_pop_idle: assert property (@(posedge clk) disable iff (!rst_n)
        pop |=> (state_reg == S_DIV || state_reg == S_OUT))
        else $error("popped job not started");

endmodule

// ===== src/uv_sphere_vertex_generator_unit.sv =====
// Top level of the UV sphere vertex generator: configuration registers and block wiring.
//
//  channel | direction | handshake          | payload
//  in      | into      | in_valid/in_stall  | restart
//  out     | out of    | out_valid/out_stall| pos_x, pos_y, pos_z, vertex_number, last
//  cfg     | into      | cfg_write          | cfg_index, cfg_data
//
//  A pole vertex goes from the queue straight to the output register; a ring vertex
//  first passes the 32-step shift-subtract divider and the 30-step CORDIC rotators.
//  The back end works on one vertex at a time; a two-entry queue lets the front keep taking.
//  rst_n clears the walk to the top pole and sets both counts to 24.
//  in_stall rises while the queue is full; a held out_stall keeps the result registered.
module uv_sphere_vertex_generator_unit #(
    parameter int MAX_STACKS = 256,
    parameter int MAX_SLICES = 256,
    parameter int FRAC_BITS  = 14
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               in_valid,
    output logic                               in_stall,
    input  logic                               restart,
    output logic                               out_valid,
    input  logic                               out_stall,
    output logic signed [usvg_pkg::OUT_W-1:0]  pos_x,
    output logic signed [usvg_pkg::OUT_W-1:0]  pos_y,
    output logic signed [usvg_pkg::OUT_W-1:0]  pos_z,
    output logic [usvg_pkg::SEQ_W-1:0]         vertex_number,
    output logic                               last,
    input  logic                               cfg_write,
    input  logic                               cfg_index,
    input  logic [usvg_pkg::CNT_W-1:0]         cfg_data
);

    logic [usvg_pkg::CNT_W-1:0] stack_count_reg, slice_count_reg;
    logic                       full, push, pop, q_valid;
    usvg_pkg::job_t             push_job, q_job;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            stack_count_reg <= usvg_pkg::CNT_W'(usvg_pkg::RESET_COUNT);
            slice_count_reg <= usvg_pkg::CNT_W'(usvg_pkg::RESET_COUNT);
        end
        else if (cfg_write)
        begin
            if (cfg_index == usvg_pkg::REG_STACK_COUNT)
                stack_count_reg <= cfg_data;
            else if (cfg_index == usvg_pkg::REG_SLICE_COUNT)
                slice_count_reg <= cfg_data;
        end
    end

    usvg_front #(
        .MAX_STACKS (MAX_STACKS),
        .MAX_SLICES (MAX_SLICES)
    ) u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .restart     (restart),
        .stack_count (stack_count_reg),
        .slice_count (slice_count_reg),
        .full        (full),
        .push        (push),
        .job         (push_job)
    );

    usvg_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .push_job (push_job),
        .full     (full),
        .pop      (pop),
        .q_valid  (q_valid),
        .q_job    (q_job)
    );

    usvg_back #(
        .FRAC_BITS (FRAC_BITS)
    ) u_back (
        .clk           (clk),
        .rst_n         (rst_n),
        .q_valid       (q_valid),
        .q_job         (q_job),
        .pop           (pop),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .pos_x         (pos_x),
        .pos_y         (pos_y),
        .pos_z         (pos_z),
        .vertex_number (vertex_number),
        .last          (last)
    );

endmodule
